/* sv/assert_macros.svh */
// Assertion macros shared by the token scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define STS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `STS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define STS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `STS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* sv/sts_pkg.sv */
// Types, character codes and classifiers for the script token scanner.
package sts_pkg;

  localparam int unsigned LINE_BITS   = 32;
  localparam int unsigned KIND_BITS   = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Token kinds as seen on the result channel.
  typedef enum logic [KIND_BITS-1:0] {
    K_EOF     = 4'd0,
    K_NEWLINE = 4'd1,
    K_INDENT  = 4'd2,
    K_COMMENT = 4'd3,
    K_STRING  = 4'd4,
    K_REGEXP  = 4'd5,
    K_STREAM  = 4'd6,
    K_PREPRO  = 4'd7,
    K_PIPE    = 4'd8,
    K_PARENT  = 4'd9,
    K_REF     = 4'd10,
    K_SPACE   = 4'd11,
    K_SYMBOL  = 4'd12,
    K_NUMBER  = 4'd13,
    K_FLAGS   = 4'd14,
    K_INVALID = 4'd15
  } kind_e;

  // Scan modes. An open token's mode carries the code of its kind, so the
  // kind of a closed token is the mode itself; two pending modes sit on the
  // codes of kinds that are never held open.
  typedef enum logic [KIND_BITS-1:0] {
    M_IDLE    = 4'd0,
    M_DOLLAR  = 4'd1,
    M_INDENT  = 4'd2,
    M_COMMENT = 4'd3,
    M_STRING  = 4'd4,
    M_REGEXP  = 4'd5,
    M_STREAM  = 4'd6,
    M_PREPRO  = 4'd7,
    M_COLON   = 4'd8,
    M_REF     = 4'd10,
    M_SPACE   = 4'd11,
    M_SYMBOL  = 4'd12,
    M_NUMBER  = 4'd13,
    M_FLAGS   = 4'd14
  } mode_e;

  // Writes into the result queue caused by one byte.
  typedef struct packed {
    logic push_a;
    logic push_b;
  } sts_push_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

/* sv/sts_if.sv */
// Channel interfaces: text bytes in, tokens out.
interface sts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface sts_tok_if #(
  parameter int unsigned LEN_BITS = 16,
  parameter int unsigned POS_BITS = 32
);
  logic                valid;
  logic                ready;
  logic [3:0]          tok_kind;
  logic [LEN_BITS-1:0] tok_len;
  logic [POS_BITS-1:0] tok_start;
  logic [31:0]         tok_line;
  logic                last_of_run;

  modport source (output valid, output tok_kind, output tok_len, output tok_start,
                  output tok_line, output last_of_run, input ready);
  modport sink (input valid, input tok_kind, input tok_len, input tok_start,
                input tok_line, input last_of_run, output ready);
endinterface

/* sv/sts_core.sv */
// Scanner state and the single-pass next-state and token logic for one byte.
`include "assert_macros.svh"

module sts_core #(
  parameter int unsigned LEN_BITS = 16,
  parameter int unsigned POS_BITS = 32,
  parameter int unsigned RES_W    = 4 + LEN_BITS + POS_BITS + 32 + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                ch_i,
  output sts_pkg::sts_push_t        push_o,
  output logic [RES_W-1:0]          res_a_o,
  output logic [RES_W-1:0]          res_b_o
);
  import sts_pkg::*;

  mode_e                mode_q, mode_d, mode_mid, mode_f;
  logic [LEN_BITS-1:0]  len_q, len_d, len_mid, len_inc;
  logic [POS_BITS-1:0]  start_q, start_d;
  logic [POS_BITS-1:0]  offset_q, offset_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic                 als_q, als_d, als_mid;

  logic                 keep, rescan, opened;
  logic                 e0_v, e1_v;
  kind_e                e0_kind, e1_kind;
  logic [LEN_BITS-1:0]  e0_len, e1_len;
  logic [7:0]           close_ch;

  assign len_inc = (&len_q) ? len_q : len_q + LEN_BITS'(1);

  // Close or extend the open token, then scan the byte afresh if needed.
  always_comb begin
    keep     = 1'b0;
    rescan   = 1'b0;
    e0_v     = 1'b0;
    e0_kind  = K_EOF;
    e0_len   = '0;
    mode_mid = mode_q;
    als_mid  = als_q;
    close_ch = (mode_q == M_STRING) ? CH_QUOTE : CH_SLASH;

    unique case (mode_q)
      M_INDENT:  keep = (ch_i == CH_TAB);
      M_COMMENT: keep = (ch_i != CH_NL) && (ch_i != CH_NUL);
      M_STRING, M_REGEXP: begin
        if (ch_i == close_ch) begin
          e0_v     = 1'b1;
          e0_kind  = kind_e'(mode_q);
          e0_len   = len_inc;
          mode_mid = M_IDLE;
          als_mid  = 1'b0;
        end else begin
          keep = (ch_i != CH_NUL);
        end
      end
      M_STREAM, M_PREPRO, M_REF, M_SYMBOL, M_FLAGS: keep = is_word(ch_i);
      M_SPACE:  keep = is_space(ch_i);
      M_NUMBER: keep = is_digit(ch_i);
      M_DOLLAR: begin
        if (ch_i == CH_DOLL || ch_i == CH_CARET) begin
          e0_v     = 1'b1;
          e0_kind  = (ch_i == CH_DOLL) ? K_PIPE : K_PARENT;
          e0_len   = LEN_BITS'(2);
          mode_mid = M_IDLE;
          als_mid  = 1'b0;
        end else if (is_word(ch_i)) begin
          mode_mid = M_REF;
          keep     = 1'b1;
        end else begin
          e0_v    = 1'b1;
          e0_kind = K_REF;
          e0_len  = LEN_BITS'(1);
          rescan  = 1'b1;
        end
      end
      M_COLON: begin
        if (is_alpha(ch_i)) begin
          mode_mid = M_FLAGS;
          keep     = 1'b1;
        end else begin
          e0_v    = 1'b1;
          e0_kind = K_INVALID;
          e0_len  = LEN_BITS'(1);
          rescan  = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    len_mid = len_q;
    if (keep) begin
      len_mid = len_inc;
      als_mid = 1'b0;
    end else if (!rescan && mode_mid != M_IDLE) begin
      e0_v    = 1'b1;
      e0_kind = kind_e'(mode_mid);
      e0_len  = len_q;
      rescan  = 1'b1;
    end else if (!rescan && !e0_v) begin
      rescan = 1'b1;
    end

    // Fresh scan of the byte as the first byte of a new token.
    e1_v    = 1'b0;
    e1_kind = K_EOF;
    e1_len  = '0;
    mode_f  = M_IDLE;
    opened  = 1'b0;
    priority if (ch_i == CH_NUL) begin
      e1_v = 1'b1;
    end else if (ch_i == CH_NL) begin
      e1_v    = 1'b1;
      e1_kind = K_NEWLINE;
      e1_len  = LEN_BITS'(1);
    end else if (ch_i == CH_TAB && als_mid) begin
      mode_f = M_INDENT;
    end else if (ch_i == CH_SEMI) begin
      mode_f = M_COMMENT;
    end else if (ch_i == CH_QUOTE) begin
      mode_f = M_STRING;
    end else if (ch_i == CH_SLASH) begin
      mode_f = M_REGEXP;
    end else if (ch_i == CH_AT) begin
      mode_f = M_STREAM;
    end else if (ch_i == CH_HASH) begin
      mode_f = M_PREPRO;
    end else if (ch_i == CH_DOLL) begin
      mode_f = M_DOLLAR;
    end else if (is_space(ch_i)) begin
      mode_f = M_SPACE;
    end else if (is_alpha(ch_i)) begin
      mode_f = M_SYMBOL;
    end else if (is_digit(ch_i)) begin
      mode_f = M_NUMBER;
    end else if (ch_i == CH_COLON) begin
      mode_f = M_COLON;
    end else begin
      e1_v    = 1'b1;
      e1_kind = K_INVALID;
      e1_len  = LEN_BITS'(1);
    end
    opened = (mode_f != M_IDLE);
    if (!rescan) begin
      e1_v = 1'b0;
    end

    // Next state.
    mode_d   = rescan ? mode_f : mode_mid;
    start_d  = (rescan && opened) ? offset_q : start_q;
    len_d    = rescan ? (opened ? LEN_BITS'(1) : '0) : len_mid;
    als_d    = rescan ? (ch_i == CH_NL) : als_mid;
    line_d   = line_q;
    if (rescan && ch_i == CH_NL && !(&line_q)) begin
      line_d = line_q + LINE_BITS'(1);
    end
    offset_d = offset_q + POS_BITS'(1);
    if (ch_i == CH_NUL) begin
      mode_d   = M_IDLE;
      offset_d = '0;
      line_d   = '0;
      als_d    = 1'b1;
    end
    if (mode_d == M_IDLE) begin
      len_d = '0;
    end
  end

  // Results in emission order; the second slot is used only for two tokens.
  always_comb begin
    push_o.push_a = step_i && (e0_v || e1_v);
    push_o.push_b = step_i && e0_v && e1_v;
    if (e0_v) begin
      res_a_o = {4'(e0_kind), e0_len, start_q, line_q, !e1_v};
    end else begin
      res_a_o = {4'(e1_kind), e1_len, offset_q, line_q, 1'b1};
    end
    res_b_o = {4'(e1_kind), e1_len, offset_q, line_q, 1'b1};
  end

  // Scanner state advances once per byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      len_q    <= '0;
      start_q  <= '0;
      offset_q <= '0;
      line_q   <= '0;
      als_q    <= 1'b1;
    end else if (step_i) begin
      mode_q   <= mode_d;
      len_q    <= len_d;
      start_q  <= start_d;
      offset_q <= offset_d;
      line_q   <= line_d;
      als_q    <= als_d;
    end
  end

  `STS_ASSERT_IMP(a_idle_len_zero, clk_i, rst_ni, mode_q == M_IDLE, len_q == '0,
                  "Idle scanner holds a non-zero token length.")
  `STS_ASSERT_NXT(a_nul_restarts, clk_i, rst_ni, step_i && ch_i == CH_NUL,
                  offset_q == '0 && line_q == '0 && als_q && mode_q == M_IDLE,
                  "End-of-text byte did not restart the counters.")
  `STS_ASSERT_IMP(a_nul_ends_eof, clk_i, rst_ni, step_i && ch_i == CH_NUL,
                  e1_v && e1_kind == K_EOF,
                  "End-of-text byte did not emit an end-of-text token.")

endmodule

/* sv/sts_tok_fifo.sv */
// Result queue taking up to two tokens per cycle and giving out one.
`include "assert_macros.svh"

module sts_tok_fifo #(
  parameter int unsigned WIDTH = 85,
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sts_pkg::sts_push_t push_i,
  input  logic [WIDTH-1:0]   data_a_i,
  input  logic [WIDTH-1:0]   data_b_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [WIDTH-1:0]   data_o
);
  import sts_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, wr_next, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop     = valid_o && ready_i;
  assign wr_next = next_ptr(wr_q);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  // Room for two tokens, the most a single byte can cause.
  assign room_o  = (cnt_q <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_d = wr_q;
    if (push_i.push_b) begin
      wr_d = next_ptr(wr_next);
    end else if (push_i.push_a) begin
      wr_d = wr_next;
    end
    rd_d  = pop ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i.push_a) + CNT_W'(push_i.push_b) - CNT_W'(pop);
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_q] <= data_a_i;
    end
    if (push_i.push_b) begin
      mem_q[wr_next] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `STS_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH),
              "Result queue count exceeds its depth.")
  `STS_ASSERT_IMP(a_pair_order, clk_i, rst_ni, push_i.push_b, push_i.push_a,
                  "Second token written without a first one.")
  `STS_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i.push_a,
                  cnt_q <= CNT_W'(DEPTH - 2),
                  "Tokens written into a full result queue.")

endmodule

/* sv/script_token_scanner.sv */
// Top level of the script token scanner.
//
// The byte channel takes one text byte per beat; a zero byte marks the end of
// a text. The token channel gives one token per beat with its kind, length,
// start offset, line and a flag on the last token that a byte caused.
// A byte is held in an input register, scanned in one pass into a four-entry
// result queue, and its first token is offered from the head of that queue.
// A byte is taken in every cycle while the queue has room for two tokens, so
// the block runs at one byte per cycle; the token channel gives at most one
// token per cycle, so a byte that closes one token and is a token itself gives
// both through the single read port of the queue, one after the other.
// Reset clears the scanner to the start of a text (offset and line zero, at
// line start, no token open) and empties the queue. When the receiver stalls,
// tokens wait in the queue and byte_i.ready drops once it cannot take two more.
module script_token_scanner #(
  parameter int unsigned LEN_BITS = 16,
  parameter int unsigned POS_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sts_byte_if.sink byte_i,
  sts_tok_if.source tok_o
);
  import sts_pkg::*;

  localparam int unsigned RES_W   = KIND_BITS + LEN_BITS + POS_BITS + LINE_BITS + 1;
  localparam int unsigned LINE_LO = 1;
  localparam int unsigned POS_LO  = LINE_LO + LINE_BITS;
  localparam int unsigned LEN_LO  = POS_LO + POS_BITS;
  localparam int unsigned KIND_LO = LEN_LO + LEN_BITS;

  logic             byte_vld_q;
  logic [7:0]       byte_q;
  logic             step;
  logic             room;
  sts_push_t        push;
  logic [RES_W-1:0] res_a, res_b, head;

  assign step         = byte_vld_q && room;
  assign byte_i.ready = !byte_vld_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      byte_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      byte_q <= byte_i.ch;
    end
  end

  sts_core #(
    .LEN_BITS (LEN_BITS),
    .POS_BITS (POS_BITS),
    .RES_W    (RES_W)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .ch_i    (byte_q),
    .push_o  (push),
    .res_a_o (res_a),
    .res_b_o (res_b)
  );

  sts_tok_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_a_i (res_a),
    .data_b_i (res_b),
    .room_o   (room),
    .valid_o  (tok_o.valid),
    .ready_i  (tok_o.ready),
    .data_o   (head)
  );

  // Unpack the token at the head of the queue.
  assign tok_o.tok_kind    = head[KIND_LO +: KIND_BITS];
  assign tok_o.tok_len     = head[LEN_LO +: LEN_BITS];
  assign tok_o.tok_start   = head[POS_LO +: POS_BITS];
  assign tok_o.tok_line    = head[LINE_LO +: LINE_BITS];
  assign tok_o.last_of_run = head[0];

endmodule
